[rtl/ills_pkg.sv]
// Shared types, codes and defaults for the indexed linked list store.
package ills_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_DUMP = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [ITEM_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [ITEM_W-1:0] read_value;
        logic                     last_of_run;
        logic [COUNT_W-1:0]       element_count;
    } t_out_item;

endpackage

[rtl/indexed_linked_list_store_top.sv]
// Linked list store: node value/link memories, free-slot stack, command sequencer.
// Append, head and tail insert: decide, alloc, resp states; clear and rejects: decide, resp.
// Mid-list insert walks one link per cycle, then links in the new node; delete walks, then unlinks.
// Dump: the first item follows a read of the head, then one per free output cycle.
// One command at a time; the input stalls until its last item enters the output register.
// Synchronous reset empties the list and marks every free-stack entry as holding its own slot.
module indexed_linked_list_store_top
    import ills_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [11:0] {
        S_IDLE       = 12'b0000_0000_0001,
        S_DECIDE     = 12'b0000_0000_0010,
        S_ALLOC      = 12'b0000_0000_0100,
        S_WALK       = 12'b0000_0000_1000,
        S_INS_A      = 12'b0000_0001_0000,
        S_INS_B      = 12'b0000_0010_0000,
        S_DEL_HEAD   = 12'b0000_0100_0000,
        S_DEL_RD     = 12'b0000_1000_0000,
        S_DEL_WR     = 12'b0001_0000_0000,
        S_DUMP_START = 12'b0010_0000_0000,
        S_DUMP       = 12'b0100_0000_0000,
        S_RESP       = 12'b1000_0000_0000
    } t_state;

    // memories
    logic signed [VALUE_BITS-1:0] r_val_mem [CAPACITY];
    logic [IDX_W-1:0]             r_link_mem [CAPACITY];
    logic [IDX_W-1:0]             r_free_mem [CAPACITY];

    logic signed [VALUE_BITS-1:0] r_val_q;
    logic [IDX_W-1:0]             r_link_q;
    logic [IDX_W-1:0]             r_free_q;
    logic                         r_free_hit;
    logic [IDX_W-1:0]             r_free_idx;

    t_state                  r_state, n_state;
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic signed [ITEM_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]        r_free_top, n_free_top;
    logic [IDX_W-1:0]        r_head, n_head;
    logic [IDX_W-1:0]        r_tail, n_tail;
    logic [CNT_W-1:0]        r_len, n_len;
    logic [IDX_W-1:0]        r_slot, n_slot;
    logic [IDX_W-1:0]        r_prev, n_prev;
    logic [IDX_W-1:0]        r_victim, n_victim;
    logic [IDX_W-1:0]        r_cur, n_cur;
    logic                    r_from_q, n_from_q;
    logic [POS_W-1:0]        r_steps, n_steps;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [CAPACITY-1:0]     r_free_set, n_free_set;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    val_we;
    logic [IDX_W-1:0]        val_wa;
    logic signed [VALUE_BITS-1:0] val_wd;
    logic                    lk_we;
    logic [IDX_W-1:0]        lk_wa;
    logic [IDX_W-1:0]        lk_wd;
    logic                    fs_we;
    logic [IDX_W-1:0]        fs_wa;
    logic [IDX_W-1:0]        fs_rd_addr;
    logic                    emit_v;
    t_out_item               emit_item;

    logic                    out_free;
    logic                    in_accept;
    logic [POS_W-1:0]        len_pos;
    logic [IDX_W-1:0]        new_slot;
    logic [IDX_W-1:0]        walk_cur;
    logic [CNT_W-1:0]        idx_next;
    logic                    dump_last;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign len_pos    = POS_W'(r_len);
    assign new_slot   = r_free_hit ? r_free_q : r_free_idx;
    assign walk_cur   = r_from_q ? r_link_q : r_cur;
    assign idx_next   = r_idx + CNT_W'(1);
    assign dump_last  = (idx_next == r_len);
    assign fs_rd_addr = IDX_W'(r_free_top - CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_pos      = r_pos;
        n_val      = r_val;
        n_free_top = r_free_top;
        n_head     = r_head;
        n_tail     = r_tail;
        n_len      = r_len;
        n_slot     = r_slot;
        n_prev     = r_prev;
        n_victim   = r_victim;
        n_cur      = r_cur;
        n_from_q   = r_from_q;
        n_steps    = r_steps;
        n_idx      = r_idx;
        n_status   = r_status;
        n_free_set = r_free_set;
        rd_en      = 1'b0;
        rd_addr    = walk_cur;
        val_we     = 1'b0;
        val_wa     = new_slot;
        val_wd     = VALUE_BITS'(r_val);
        lk_we      = 1'b0;
        lk_wa      = new_slot;
        lk_wd      = r_head;
        fs_we      = 1'b0;
        fs_wa      = IDX_W'(r_free_top);
        emit_v     = 1'b0;
        emit_item  = '{status: r_status, read_value: '0, last_of_run: 1'b1,
                       element_count: COUNT_W'(r_len)};

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd   = i_in_item.command;
                    n_pos   = i_in_item.position;
                    n_val   = i_in_item.item_value;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (r_cmd) inside
                    CMD_APPEND, CMD_INSERT: begin
                        if (r_free_top == '0 || r_len >= CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else if (r_cmd == CMD_APPEND) begin
                            n_pos   = len_pos;
                            n_state = S_ALLOC;
                        end else if (r_len != '0 && r_pos > len_pos) begin
                            n_status = ST_RANGE;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end
                    CMD_DELETE: begin
                        if (r_len == '0 || r_pos >= len_pos) begin
                            n_status = ST_RANGE;
                            n_state  = S_RESP;
                        end else begin
                            n_cur    = r_head;
                            n_from_q = 1'b0;
                            n_steps  = (r_pos == '0) ? '0 : r_pos - POS_W'(1);
                            n_state  = S_WALK;
                        end
                    end
                    CMD_DUMP: begin
                        if (r_len == '0) begin
                            n_status = ST_EMPTY_DUMP;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_DUMP_START;
                        end
                    end
                    CMD_CLEAR: begin
                        n_free_top = CNT_W'(CAPACITY);
                        n_free_set = '0;
                        n_head     = '0;
                        n_tail     = '0;
                        n_len      = '0;
                        n_status   = ST_OK;
                        n_state    = S_RESP;
                    end
                    default: begin
                        n_status = ST_RANGE;
                        n_state  = S_RESP;
                    end
                endcase
            end
            S_ALLOC: begin
                // pop the slot read from the free stack and store the value
                n_slot     = new_slot;
                val_we     = 1'b1;
                n_free_top = r_free_top - CNT_W'(1);
                n_status   = ST_OK;
                if (r_len == '0 || r_pos == '0) begin
                    lk_we  = 1'b1;
                    n_head = new_slot;
                    if (r_len == '0) begin
                        n_tail = new_slot;
                    end
                    n_len   = r_len + CNT_W'(1);
                    n_state = S_RESP;
                end else if (r_pos == len_pos) begin
                    lk_we   = 1'b1;
                    lk_wa   = r_tail;
                    lk_wd   = new_slot;
                    n_tail  = new_slot;
                    n_len   = r_len + CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    n_cur    = r_head;
                    n_from_q = 1'b0;
                    n_steps  = r_pos - POS_W'(1);
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                // follow one link per cycle; the last read fetches the link of prev
                rd_en   = 1'b1;
                rd_addr = walk_cur;
                if (r_steps == '0) begin
                    n_prev = walk_cur;
                    if (r_cmd == CMD_DELETE) begin
                        n_state = (r_pos == '0) ? S_DEL_HEAD : S_DEL_RD;
                    end else begin
                        n_state = S_INS_A;
                    end
                end else begin
                    n_steps  = r_steps - POS_W'(1);
                    n_from_q = 1'b1;
                end
            end
            S_INS_A: begin
                lk_we   = 1'b1;
                lk_wa   = r_slot;
                lk_wd   = r_link_q;
                n_state = S_INS_B;
            end
            S_INS_B: begin
                lk_we   = 1'b1;
                lk_wa   = r_prev;
                lk_wd   = r_slot;
                n_len   = r_len + CNT_W'(1);
                n_state = S_RESP;
            end
            S_DEL_HEAD: begin
                n_head     = r_link_q;
                fs_we      = 1'b1;
                n_free_set[IDX_W'(r_free_top)] = 1'b1;
                n_free_top = r_free_top + CNT_W'(1);
                n_len      = r_len - CNT_W'(1);
                n_victim   = r_prev;
                n_status   = ST_OK;
                n_state    = S_RESP;
            end
            S_DEL_RD: begin
                n_victim = r_link_q;
                rd_en    = 1'b1;
                rd_addr  = r_link_q;
                n_state  = S_DEL_WR;
            end
            S_DEL_WR: begin
                lk_we      = 1'b1;
                lk_wa      = r_prev;
                lk_wd      = r_link_q;
                if (r_pos == POS_W'(r_len - CNT_W'(1))) begin
                    n_tail = r_prev;
                end
                fs_we      = 1'b1;
                n_free_set[IDX_W'(r_free_top)] = 1'b1;
                n_free_top = r_free_top + CNT_W'(1);
                n_len      = r_len - CNT_W'(1);
                n_status   = ST_OK;
                n_state    = S_RESP;
            end
            S_DUMP_START: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_idx   = '0;
                n_state = S_DUMP;
            end
            S_DUMP: begin
                // hold the read data while the output is stalled
                if (out_free) begin
                    emit_v    = 1'b1;
                    emit_item = '{status: ST_OK, read_value: ITEM_W'(r_val_q),
                                  last_of_run: dump_last,
                                  element_count: COUNT_W'(r_len)};
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_link_q;
                        n_idx   = idx_next;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    emit_v  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_top  <= CNT_W'(CAPACITY);
            r_head      <= '0;
            r_tail      <= '0;
            r_len       <= '0;
            r_free_set  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_top <= n_free_top;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_len      <= n_len;
            r_free_set <= n_free_set;
            if (out_free) begin
                r_out_valid <= emit_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_slot   <= n_slot;
        r_prev   <= n_prev;
        r_victim <= n_victim;
        r_cur    <= n_cur;
        r_from_q <= n_from_q;
        r_steps  <= n_steps;
        r_idx    <= n_idx;
        r_status <= n_status;
        if (out_free && emit_v) begin
            r_out <= emit_item;
        end
    end

    // node memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[val_wa] <= val_wd;
        end
        if (rd_en) begin
            r_val_q <= r_val_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            r_link_mem[lk_wa] <= lk_wd;
        end
        if (rd_en) begin
            r_link_q <= r_link_mem[rd_addr];
        end
    end

    // free-slot stack: an entry never written since clear reads as its own index
    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_free_mem[fs_wa] <= n_victim;
        end
        r_free_q   <= r_free_mem[fs_rd_addr];
        r_free_hit <= r_free_set[fs_rd_addr];
        r_free_idx <= fs_rd_addr;
    end

endmodule

[rtl/ills_check.sv]
// Port-level checks for the linked list store, bound to its top level.
module ills_check
    import ills_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // no new command while a dump is still in flight
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last_of_run |-> o_in_stall)
        else $error("input open during a multi-item run");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.element_count <= 7'(CAPACITY))
        else $error("element count above capacity");

    // error answers are single items with zero value
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |->
            o_out_item.last_of_run && o_out_item.read_value == '0)
        else $error("error item malformed");

    a_empty_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_EMPTY_DUMP |->
            o_out_item.element_count == '0)
        else $error("empty-dump status with nonzero count");

endmodule

bind indexed_linked_list_store_top ills_check #(.CAPACITY(CAPACITY)) u_ills_check (.*);
